// ----- src/urb_pkg.sv -----
// urb_pkg: constants, codes and helpers for the 16550-style uart register block
// no dependencies; imported by the top level, the checker and the testbench
`default_nettype none

package urb_pkg;

    // fifo geometry
    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;

    // transaction kinds
    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_LINE_RX = 2'd2;
    localparam logic [1:0] OP_LINE_TX = 2'd3;

    // register offsets
    localparam logic [2:0] REG_DATA = 3'd0;
    localparam logic [2:0] REG_IER  = 3'd1;
    localparam logic [2:0] REG_ISR  = 3'd2;
    localparam logic [2:0] REG_LCR  = 3'd3;
    localparam logic [2:0] REG_LSR  = 3'd5;

    // register bits
    localparam int LCR_DLAB_BIT     = 7;
    localparam int IER_RX_BIT       = 0;
    localparam int IER_TX_BIT       = 1;
    localparam int FCR_ENABLE_BIT   = 0;
    localparam int FCR_CLEAR_RX_BIT = 1;
    localparam int FCR_CLEAR_TX_BIT = 2;

    // interrupt status codes
    localparam logic [7:0] ISR_FIFO_ON = 8'hC0;
    localparam logic [7:0] ISR_RX_DATA = 8'h04;
    localparam logic [7:0] ISR_TX_EMPTY = 8'h02;
    localparam logic [7:0] ISR_NONE    = 8'h01;

    // line status bits
    localparam logic [7:0] LSR_DATA_READY = 8'h01;
    localparam logic [7:0] LSR_OVERRUN    = 8'h02;
    localparam logic [7:0] LSR_TX_EMPTY   = 8'h60;

    // circular pointer advance
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(FIFO_DEPTH - 1))
            res = '0;
        else
            res = ptr + PTR_W'(1);
        return res;
    endfunction

    // slot behind the last stored byte
    function automatic logic [PTR_W-1:0] wr_index(input logic [PTR_W-1:0] ptr,
                                                  input logic [CNT_W-1:0] cnt);
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] wrapped;
        sum = SUM_W'(ptr) + SUM_W'(cnt);
        if (sum >= SUM_W'(FIFO_DEPTH))
            wrapped = sum - SUM_W'(FIFO_DEPTH);
        else
            wrapped = sum;
        return wrapped[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/urb_if.sv -----
// urb_req_if / urb_rsp_if: valid/ready channels of the uart register block
// depends on nothing; payload widths fixed by the register block's fields
`default_nettype none

interface urb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] line_rx_byte;

    modport source (output valid, operation, reg_offset, write_data, line_rx_byte,
                    input ready);
    modport sink   (input valid, operation, reg_offset, write_data, line_rx_byte,
                    output ready);
endinterface

interface urb_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       line_tx_valid;
    logic [7:0] line_tx_byte;
    logic       irq;

    modport source (output valid, read_data, line_tx_valid, line_tx_byte, irq,
                    input ready);
    modport sink   (input valid, read_data, line_tx_valid, line_tx_byte, irq,
                    output ready);
endinterface

`default_nettype wire

// ----- src/uart_16550_register_block_top.sv -----
// an accepted transaction's result appears in the output register in the next cycle
// throughput: one transaction per cycle; req.ready is high while the output register
// is empty or its result is taken in the same cycle
// reset: rst_n clears the architectural registers, pointers, counts and the output valid at once;
// fifo byte storage is not cleared and is only read after it was written
// depends on urb_pkg and the urb_req_if / urb_rsp_if channel interfaces
`default_nettype none

module uart_16550_register_block_top
    import urb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    urb_req_if.sink   req,
    urb_rsp_if.source rsp
);

    // architectural registers
    logic [7:0]       lcr_reg, lcr_next;
    logic [3:0]       ier_reg, ier_next;
    logic [7:0]       dll_reg, dll_next;
    logic [7:0]       dlm_reg, dlm_next;
    logic             fifo_en_reg, fifo_en_next;
    logic             overrun_reg, overrun_next;
    logic [PTR_W-1:0] rx_ptr_reg, rx_ptr_next;
    logic [CNT_W-1:0] rx_cnt_reg, rx_cnt_next;
    logic [PTR_W-1:0] tx_ptr_reg, tx_ptr_next;
    logic [CNT_W-1:0] tx_cnt_reg, tx_cnt_next;

    // fifo storage
    logic [7:0] rx_store_reg [FIFO_DEPTH];
    logic [7:0] tx_store_reg [FIFO_DEPTH];

    // output register
    logic       rsp_valid_reg;
    logic [7:0] read_data_reg, read_data_next;
    logic       tx_valid_reg, tx_valid_next;
    logic [7:0] tx_byte_reg, tx_byte_next;
    logic       irq_reg, irq_next;

    logic             accept;
    logic             dlab;
    logic             rx_full;
    logic             tx_full;
    logic             rx_we;
    logic             tx_we;
    logic [PTR_W-1:0] rx_wr_idx;
    logic [PTR_W-1:0] tx_wr_idx;
    logic [7:0]       isr_value;

    // handshake
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign dlab      = lcr_reg[LCR_DLAB_BIT];
    assign rx_full   = (rx_cnt_reg == CNT_W'(FIFO_DEPTH));
    assign tx_full   = (tx_cnt_reg == CNT_W'(FIFO_DEPTH));
    assign rx_wr_idx = wr_index(rx_ptr_reg, rx_cnt_reg);
    assign tx_wr_idx = wr_index(tx_ptr_reg, tx_cnt_reg);

    // fifo pushes
    assign rx_we = accept && (req.operation == OP_LINE_RX) && !rx_full;
    assign tx_we = accept && (req.operation == OP_WRITE) && (req.reg_offset == REG_DATA)
                   && !dlab && !tx_full;

    // interrupt status in 16550 encoding
    always_comb
    begin
        isr_value = fifo_en_reg ? ISR_FIFO_ON : 8'h00;
        if (ier_reg[IER_RX_BIT] && (rx_cnt_reg != '0))
            isr_value = isr_value | ISR_RX_DATA;
        else if (ier_reg[IER_TX_BIT] && (tx_cnt_reg == '0))
            isr_value = isr_value | ISR_TX_EMPTY;
        else
            isr_value = isr_value | ISR_NONE;
    end

    // per-transaction register update and result
    always_comb
    begin
        lcr_next       = lcr_reg;
        ier_next       = ier_reg;
        dll_next       = dll_reg;
        dlm_next       = dlm_reg;
        fifo_en_next   = fifo_en_reg;
        overrun_next   = overrun_reg;
        rx_ptr_next    = rx_ptr_reg;
        rx_cnt_next    = rx_cnt_reg;
        tx_ptr_next    = tx_ptr_reg;
        tx_cnt_next    = tx_cnt_reg;
        read_data_next = 8'h00;
        tx_valid_next  = 1'b0;
        tx_byte_next   = 8'h00;

        case (req.operation)
            OP_READ:
            begin
                case (req.reg_offset)
                    REG_DATA:
                    begin
                        if (dlab)
                        begin
                            read_data_next = dll_reg;
                        end
                        else if (rx_cnt_reg != '0)
                        begin
                            read_data_next = rx_store_reg[rx_ptr_reg];
                            rx_ptr_next    = ptr_inc(rx_ptr_reg);
                            rx_cnt_next    = rx_cnt_reg - CNT_W'(1);
                        end
                    end
                    REG_IER: read_data_next = dlab ? dlm_reg : {4'h0, ier_reg};
                    REG_ISR: read_data_next = isr_value;
                    REG_LCR: read_data_next = lcr_reg;
                    REG_LSR:
                    begin
                        read_data_next = ((rx_cnt_reg != '0) ? LSR_DATA_READY : 8'h00)
                                       | (overrun_reg ? LSR_OVERRUN : 8'h00)
                                       | ((tx_cnt_reg == '0) ? LSR_TX_EMPTY : 8'h00);
                        overrun_next   = 1'b0;
                    end
                    default: read_data_next = 8'h00;
                endcase
            end
            OP_WRITE:
            begin
                case (req.reg_offset)
                    REG_DATA:
                    begin
                        if (dlab)
                            dll_next = req.write_data;
                        else if (!tx_full)
                            tx_cnt_next = tx_cnt_reg + CNT_W'(1);
                    end
                    REG_IER:
                    begin
                        if (dlab)
                            dlm_next = req.write_data;
                        else
                            ier_next = req.write_data[3:0];
                    end
                    REG_ISR:
                    begin
                        fifo_en_next = req.write_data[FCR_ENABLE_BIT];
                        if (req.write_data[FCR_CLEAR_RX_BIT])
                        begin
                            rx_ptr_next = '0;
                            rx_cnt_next = '0;
                        end
                        if (req.write_data[FCR_CLEAR_TX_BIT])
                        begin
                            tx_ptr_next = '0;
                            tx_cnt_next = '0;
                        end
                    end
                    REG_LCR: lcr_next = req.write_data;
                    default: lcr_next = lcr_reg;
                endcase
            end
            OP_LINE_RX:
            begin
                if (!rx_full)
                    rx_cnt_next = rx_cnt_reg + CNT_W'(1);
                else
                    overrun_next = 1'b1;
            end
            OP_LINE_TX:
            begin
                if (tx_cnt_reg != '0)
                begin
                    tx_byte_next  = tx_store_reg[tx_ptr_reg];
                    tx_valid_next = 1'b1;
                    tx_ptr_next   = ptr_inc(tx_ptr_reg);
                    tx_cnt_next   = tx_cnt_reg - CNT_W'(1);
                end
            end
            default: tx_valid_next = 1'b0;
        endcase

        irq_next = (ier_next[IER_RX_BIT] && (rx_cnt_next != '0))
                || (ier_next[IER_TX_BIT] && (tx_cnt_next == '0));
    end

    // control state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcr_reg       <= '0;
            ier_reg       <= '0;
            dll_reg       <= '0;
            dlm_reg       <= '0;
            fifo_en_reg   <= 1'b0;
            overrun_reg   <= 1'b0;
            rx_ptr_reg    <= '0;
            rx_cnt_reg    <= '0;
            tx_ptr_reg    <= '0;
            tx_cnt_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                lcr_reg     <= lcr_next;
                ier_reg     <= ier_next;
                dll_reg     <= dll_next;
                dlm_reg     <= dlm_next;
                fifo_en_reg <= fifo_en_next;
                overrun_reg <= overrun_next;
                rx_ptr_reg  <= rx_ptr_next;
                rx_cnt_reg  <= rx_cnt_next;
                tx_ptr_reg  <= tx_ptr_next;
                tx_cnt_reg  <= tx_cnt_next;
            end
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= read_data_next;
            tx_valid_reg  <= tx_valid_next;
            tx_byte_reg   <= tx_byte_next;
            irq_reg       <= irq_next;
        end
    end

    // fifo byte storage
    always_ff @(posedge clk)
    begin
        if (rx_we)
            rx_store_reg[rx_wr_idx] <= req.line_rx_byte;
        if (tx_we)
            tx_store_reg[tx_wr_idx] <= req.write_data;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.read_data     = read_data_reg;
    assign rsp.line_tx_valid = tx_valid_reg;
    assign rsp.line_tx_byte  = tx_byte_reg;
    assign rsp.irq           = irq_reg;

endmodule

`default_nettype wire

// ----- src/urb_checker.sv -----
// urb_checker: port-level assertions for the uart register block, bound to the top level
// depends on urb_pkg and on the top level's req / rsp channel ports
`default_nettype none

module urb_checker
    import urb_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic [1:0] req_operation,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [7:0] rsp_read_data,
    input wire logic       rsp_line_tx_valid,
    input wire logic [7:0] rsp_line_tx_byte,
    input wire logic       rsp_irq
);

    // every accepted transaction shows its result in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> rsp_valid)
        else $error("result missing one cycle after accepted transaction");

    // only bus reads return data
    a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_operation != OP_READ)) |=> (rsp_read_data == 8'h00))
        else $error("read data nonzero for a non-read transaction");

    // only transmit slots hand a byte to the line
    a_tx_only: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_operation != OP_LINE_TX)) |=> !rsp_line_tx_valid)
        else $error("line byte handed out outside a transmit slot");

    // a result without line_tx_valid carries a zero byte
    a_tx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_line_tx_valid) |-> (rsp_line_tx_byte == 8'h00))
        else $error("line byte nonzero without line_tx_valid");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_data)
            && $stable(rsp_line_tx_valid) && $stable(rsp_line_tx_byte) && $stable(rsp_irq)))
        else $error("stalled result changed");

endmodule

bind uart_16550_register_block_top urb_checker u_urb_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_operation     (req.operation),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_read_data     (rsp.read_data),
    .rsp_line_tx_valid (rsp.line_tx_valid),
    .rsp_line_tx_byte  (rsp.line_tx_byte),
    .rsp_irq           (rsp.irq)
);

`default_nettype wire

// ----- bench/testbench.sv -----
// testbench for uart_16550_register_block_top: directed and random register, line rx
// and line tx transactions, each result checked against an in-bench register/fifo model
// depends on urb_pkg, urb_req_if / urb_rsp_if and the top level in src
`default_nettype none

module testbench
    import urb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_EDGES = 4;

    typedef struct packed {
        logic [7:0] read_data;
        logic       line_tx_valid;
        logic [7:0] line_tx_byte;
        logic       irq;
    } uart_result_t;

    logic clk;
    logic rst_n;

    urb_req_if req_ch();
    urb_rsp_if rsp_ch();

    uart_16550_register_block_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the uart registers and fifos
    logic [7:0] lcr_shadow;
    logic [3:0] ier_shadow;
    logic [7:0] dll_shadow;
    logic [7:0] dlm_shadow;
    logic       fifo_on_shadow;
    logic       overrun_shadow;
    logic [7:0] rx_bytes [FIFO_DEPTH];
    int         rx_head;
    int         rx_fill;
    logic [7:0] tx_bytes [FIFO_DEPTH];
    int         tx_head;
    int         tx_fill;

    uart_result_t expected_results[$];
    int           error_count;
    int           idle_cycles;
    bit           steady_flow;
    bit           hold_request;

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5ns clk = ~clk;

    // apply one transaction to the shadow state and return its result
    function automatic uart_result_t predict_uart(input logic [1:0] op,
                                                  input logic [2:0] off,
                                                  input logic [7:0] wd,
                                                  input logic [7:0] rxb);
        uart_result_t res;
        logic         dlab;
        logic         rx_pend;
        logic         tx_pend;
        res     = '0;
        dlab    = lcr_shadow[LCR_DLAB_BIT];
        rx_pend = ier_shadow[IER_RX_BIT] && (rx_fill != 0);
        tx_pend = ier_shadow[IER_TX_BIT] && (tx_fill == 0);
        case (op)
            OP_READ:
            begin
                case (off)
                    REG_DATA:
                    begin
                        if (dlab)
                            res.read_data = dll_shadow;
                        else if (rx_fill != 0)
                        begin
                            res.read_data = rx_bytes[rx_head];
                            rx_head = (rx_head + 1) % FIFO_DEPTH;
                            rx_fill--;
                        end
                    end
                    REG_IER: res.read_data = dlab ? dlm_shadow : {4'h0, ier_shadow};
                    REG_ISR:
                    begin
                        res.read_data = fifo_on_shadow ? ISR_FIFO_ON : 8'h00;
                        if (rx_pend)
                            res.read_data |= ISR_RX_DATA;
                        else if (tx_pend)
                            res.read_data |= ISR_TX_EMPTY;
                        else
                            res.read_data |= ISR_NONE;
                    end
                    REG_LCR: res.read_data = lcr_shadow;
                    REG_LSR:
                    begin
                        if (rx_fill != 0)
                            res.read_data |= LSR_DATA_READY;
                        if (overrun_shadow)
                            res.read_data |= LSR_OVERRUN;
                        if (tx_fill == 0)
                            res.read_data |= LSR_TX_EMPTY;
                        overrun_shadow = 1'b0;
                    end
                    default: ;
                endcase
            end
            OP_WRITE:
            begin
                case (off)
                    REG_DATA:
                    begin
                        if (dlab)
                            dll_shadow = wd;
                        else if (tx_fill < FIFO_DEPTH)
                        begin
                            tx_bytes[(tx_head + tx_fill) % FIFO_DEPTH] = wd;
                            tx_fill++;
                        end
                    end
                    REG_IER:
                    begin
                        if (dlab)
                            dlm_shadow = wd;
                        else
                            ier_shadow = wd[3:0];
                    end
                    REG_ISR:
                    begin
                        fifo_on_shadow = wd[FCR_ENABLE_BIT];
                        if (wd[FCR_CLEAR_RX_BIT])
                        begin
                            rx_head = 0;
                            rx_fill = 0;
                        end
                        if (wd[FCR_CLEAR_TX_BIT])
                        begin
                            tx_head = 0;
                            tx_fill = 0;
                        end
                    end
                    REG_LCR: lcr_shadow = wd;
                    default: ;
                endcase
            end
            OP_LINE_RX:
            begin
                if (rx_fill < FIFO_DEPTH)
                begin
                    rx_bytes[(rx_head + rx_fill) % FIFO_DEPTH] = rxb;
                    rx_fill++;
                end
                else
                    overrun_shadow = 1'b1;
            end
            default:
            begin
                if (tx_fill != 0)
                begin
                    res.line_tx_valid = 1'b1;
                    res.line_tx_byte  = tx_bytes[tx_head];
                    tx_head = (tx_head + 1) % FIFO_DEPTH;
                    tx_fill--;
                end
            end
        endcase
        res.irq = (ier_shadow[IER_RX_BIT] && (rx_fill != 0)) ||
                  (ier_shadow[IER_TX_BIT] && (tx_fill == 0));
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, want, got);
            error_count++;
        end
    endtask

    // sample both channels mid-cycle; a transaction seen here completes at the next edge
    always @(negedge clk)
    begin
        uart_result_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: read_data %02h tx %0d/%02h irq %0d",
                             $time, rsp_ch.read_data, rsp_ch.line_tx_valid,
                             rsp_ch.line_tx_byte, rsp_ch.irq);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.read_data, rsp_ch.read_data);
                    check_field("line_tx_valid", 8'(want.line_tx_valid),
                                8'(rsp_ch.line_tx_valid));
                    check_field("line_tx_byte", want.line_tx_byte, rsp_ch.line_tx_byte);
                    check_field("irq", 8'(want.irq), 8'(rsp_ch.irq));
                end
            end
            if (req_ch.valid && req_ch.ready)
                expected_results.push_back(predict_uart(req_ch.operation, req_ch.reg_offset,
                                                        req_ch.write_data,
                                                        req_ch.line_rx_byte));
            // watchdog on cycles with no transaction on either side
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, %0d results outstanding", $time,
                         expected_results.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // result side ready: random stalls, plus a long hold when requested
    initial
    begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (steady_flow || $urandom_range(0, 99) < 75)
                rsp_ch.ready <= 1'b1;
            else
            begin
                rsp_ch.ready <= 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
            end
        end
    end

    // offer one transaction after a random gap, return at the edge that takes it
    task automatic send_txn(input logic [1:0] op, input logic [2:0] off,
                            input logic [7:0] wd, input logic [7:0] rxb);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (steady_flow || pick < 60)
            gap = 0;
        else if (pick < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.reg_offset   <= off;
        req_ch.write_data   <= wd;
        req_ch.line_rx_byte <= rxb;
        do
            @(negedge clk);
        while (!req_ch.ready);
        @(posedge clk);
    endtask

    task automatic bus_read(input logic [2:0] off);
        send_txn(OP_READ, off, 8'($urandom), 8'($urandom));
    endtask

    task automatic bus_write(input logic [2:0] off, input logic [7:0] wd);
        send_txn(OP_WRITE, off, wd, 8'($urandom));
    endtask

    task automatic line_rx(input logic [7:0] rxb);
        send_txn(OP_LINE_RX, 3'($urandom), 8'($urandom), rxb);
    endtask

    task automatic line_slot();
        send_txn(OP_LINE_TX, 3'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // one random transaction; weights in percent, reads take the remainder
    task automatic send_random(input int rx_pct, input int slot_pct, input int wr_pct);
        int         pick;
        int         sel;
        logic [7:0] wd;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 9);
        wd   = 8'($urandom);
        if (pick < rx_pct)
            line_rx(8'($urandom));
        else if (pick < rx_pct + slot_pct)
            line_slot();
        else if (pick < rx_pct + slot_pct + wr_pct)
        begin
            case (sel)
                6:
                begin
                    // fifo clears kept rare so the fifos get to fill
                    if ($urandom_range(0, 3) != 0)
                        wd[2:1] = 2'b00;
                    bus_write(REG_ISR, wd);
                end
                7:
                begin
                    if ($urandom_range(0, 3) != 0)
                        wd[LCR_DLAB_BIT] = 1'b0;
                    bus_write(REG_LCR, wd);
                end
                8:       bus_write(3'($urandom), wd);
                5, 9:    bus_write(REG_IER, wd);
                default: bus_write(REG_DATA, wd);
            endcase
        end
        else
        begin
            case (sel)
                4, 5:    bus_read(REG_LSR);
                6:       bus_read(REG_ISR);
                7:       bus_read(REG_IER);
                8:       bus_read(REG_LCR);
                9:       bus_read(3'($urandom));
                default: bus_read(REG_DATA);
            endcase
        end
    endtask

    // values right after reset and empty-fifo behavior
    task automatic test_reset_state();
        bus_read(REG_ISR);
        bus_read(REG_LSR);
        bus_read(REG_DATA);
        line_slot();
        bus_read(REG_LCR);
    endtask

    // dlab switches offsets 0 and 1 to the divisor latch
    task automatic test_divisor_latch();
        bus_write(REG_IER, 8'hFF);
        bus_read(REG_IER);
        bus_write(REG_LCR, 8'h83);
        bus_write(REG_DATA, 8'hFF);
        bus_write(REG_IER, 8'h00);
        bus_read(REG_DATA);
        bus_read(REG_IER);
        bus_write(REG_LCR, 8'h03);
        bus_read(REG_IER);
    endtask

    // unmapped offsets and the read-only line status register
    task automatic test_register_map();
        for (int off = 4; off < 8; off++)
            bus_write(3'(off), 8'hFF);
        bus_read(3'd4);
        bus_read(3'd6);
        bus_read(3'd7);
    endtask

    // fifo enable, receive data pending and interrupt status encoding
    task automatic test_fifo_control();
        bus_write(REG_ISR, 8'h07);
        bus_read(REG_ISR);
        line_rx(8'h00);
        line_rx(8'hFF);
        bus_read(REG_ISR);
        bus_read(REG_LSR);
        bus_read(REG_DATA);
        bus_read(REG_DATA);
        bus_write(REG_DATA, 8'hA5);
        line_slot();
    endtask

    // receive bursts around and past the fifo depth, overrun seen and cleared in line status
    task automatic test_rx_overrun(input int bursts);
        bus_write(REG_LCR, 8'h03);
        bus_write(REG_IER, 8'($urandom));
        repeat (bursts)
        begin
            repeat ($urandom_range(FIFO_DEPTH - 2, FIFO_DEPTH + 4))
                line_rx(8'($urandom));
            repeat ($urandom_range(1, 2))
                bus_read(REG_LSR);
            repeat ($urandom_range(0, FIFO_DEPTH + 4))
            begin
                if ($urandom_range(0, 4) == 0)
                    send_random(20, 20, 30);
                else
                    bus_read(REG_DATA);
            end
        end
    endtask

    // transmit bursts around and past the fifo depth, then drained by line slots
    task automatic test_tx_full(input int bursts);
        bus_write(REG_LCR, 8'h03);
        bus_write(REG_IER, 8'($urandom));
        repeat (bursts)
        begin
            repeat ($urandom_range(FIFO_DEPTH - 2, FIFO_DEPTH + 4))
                bus_write(REG_DATA, 8'($urandom));
            bus_read(REG_LSR);
            if ($urandom_range(0, 5) == 0)
                bus_write(REG_ISR, 8'h05);
            repeat ($urandom_range(4, FIFO_DEPTH + 4))
            begin
                if ($urandom_range(0, 4) == 0)
                    send_random(20, 20, 30);
                else
                    line_slot();
            end
        end
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count)
            send_random(25, 20, 30);
    endtask

    // result side held off while transactions keep coming
    task automatic test_backpressure(input int count);
        steady_flow  = 1'b1;
        hold_request = 1'b1;
        repeat (count)
            send_random(25, 25, 25);
        steady_flow = 1'b0;
    endtask

    // no idling on either side
    task automatic test_back_to_back(input int count);
        steady_flow = 1'b1;
        repeat (count)
            send_random(25, 25, 25);
        steady_flow = 1'b0;
    endtask

    // reset, test sequence, drain and verdict
    initial
    begin
        error_count    = 0;
        idle_cycles    = 0;
        steady_flow    = 1'b0;
        hold_request   = 1'b0;
        lcr_shadow     = '0;
        ier_shadow     = '0;
        dll_shadow     = '0;
        dlm_shadow     = '0;
        fifo_on_shadow = 1'b0;
        overrun_shadow = 1'b0;
        rx_head        = 0;
        rx_fill        = 0;
        tx_head        = 0;
        tx_fill        = 0;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.operation    = OP_READ;
        req_ch.reg_offset   = REG_DATA;
        req_ch.write_data   = '0;
        req_ch.line_rx_byte = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_divisor_latch();
        test_register_map();
        test_fifo_control();
        test_random_traffic(300);
        test_rx_overrun(10);
        test_tx_full(10);
        test_backpressure(80);
        test_back_to_back(200);
        test_random_traffic(300);

        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_EDGES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
